// ===== hw/rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_DATA   = 3'd0,
        ST_CLOSED = 3'd1,
        ST_UNTERM = 3'd2,
        ST_BADESC = 3'd3,
        ST_BADHEX = 3'd4,
        ST_NOLOW  = 3'd5,
        ST_BADLOW = 3'd6,
        ST_CTRL   = 3'd7
    } t_status;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_HEX1   = 3'd2,
        MODE_BSL    = 3'd3,
        MODE_U      = 3'd4,
        MODE_HEX2   = 3'd5
    } t_mode;

    // One job handed from the front to the back: up to four bytes
    typedef struct packed {
        logic [3:0][7:0] bytes;     // byte 0 goes out first
        logic [1:0]      last_idx;  // index of the final byte
        t_status         status;
    } t_job;

    localparam int QDEPTH = 2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

endpackage

// ===== hw/rtl/jsu_front.sv =====
// Front end: escape scanner that turns each accepted byte into at most one job.
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_end,
    input  logic [7:0]    i_byte,
    output logic          o_push,
    output jsu_pkg::t_job o_job
);

    jsu_pkg::t_mode r_mode, n_mode;
    logic [1:0]     r_cnt, n_cnt;
    logic [15:0]    r_acc, n_acc;
    logic [9:0]     r_high, n_high;

    // Hex digit value, bit 4 set when not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39)      v = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
        else                               v = 5'h10;
        return v;
    endfunction

    function automatic jsu_pkg::t_job job_status(input jsu_pkg::t_status st);
        jsu_pkg::t_job j;
        j.bytes    = '0;
        j.last_idx = 2'd0;
        j.status   = st;
        return j;
    endfunction

    function automatic jsu_pkg::t_job job_byte(input logic [7:0] b);
        jsu_pkg::t_job j;
        j.bytes    = {24'd0, b};
        j.last_idx = 2'd0;
        j.status   = jsu_pkg::ST_DATA;
        return j;
    endfunction

    // UTF-8 encoding of a code point
    function automatic jsu_pkg::t_job job_utf8(input logic [20:0] cp);
        jsu_pkg::t_job j;
        j.bytes  = '0;
        j.status = jsu_pkg::ST_DATA;
        if (cp <= 21'h7F) begin
            j.bytes[0] = cp[7:0];
            j.last_idx = 2'd0;
        end else if (cp <= 21'h7FF) begin
            j.bytes[0] = {3'b110, cp[10:6]};
            j.bytes[1] = {2'b10, cp[5:0]};
            j.last_idx = 2'd1;
        end else if (cp <= 21'hFFFF) begin
            j.bytes[0] = {4'b1110, cp[15:12]};
            j.bytes[1] = {2'b10, cp[11:6]};
            j.bytes[2] = {2'b10, cp[5:0]};
            j.last_idx = 2'd2;
        end else begin
            j.bytes[0] = {5'b11110, cp[20:18]};
            j.bytes[1] = {2'b10, cp[17:12]};
            j.bytes[2] = {2'b10, cp[11:6]};
            j.bytes[3] = {2'b10, cp[5:0]};
            j.last_idx = 2'd3;
        end
        return j;
    endfunction

    logic [4:0]  w_hex;
    logic [15:0] w_acc;
    logic [20:0] w_pair;

    assign w_hex  = hex_val(i_byte);
    assign w_acc  = {r_acc[11:0], w_hex[3:0]};
    // 0x10000 + (high << 10) + (low - 0xDC00)
    assign w_pair = {11'(r_high) + 11'd64, w_acc[9:0]};

    // Next state and job
    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_high = r_high;
        o_push = 1'b0;
        o_job  = job_status(jsu_pkg::ST_DATA);
        if (i_accept) begin
            if (i_end) begin
                o_push = 1'b1;
                o_job  = job_status(jsu_pkg::ST_UNTERM);
                n_mode = jsu_pkg::MODE_NORMAL;
                n_cnt  = '0;
                n_acc  = '0;
                n_high = '0;
            end else begin
                unique case (r_mode) inside
                    jsu_pkg::MODE_ESC: begin
                        n_mode = jsu_pkg::MODE_NORMAL;
                        o_push = 1'b1;
                        unique case (i_byte)
                            jsu_pkg::CH_QUOTE: o_job = job_byte(8'h22);
                            jsu_pkg::CH_BSL:   o_job = job_byte(8'h5C);
                            jsu_pkg::CH_SLASH: o_job = job_byte(8'h2F);
                            jsu_pkg::CH_B:     o_job = job_byte(8'h08);
                            jsu_pkg::CH_F:     o_job = job_byte(8'h0C);
                            jsu_pkg::CH_N:     o_job = job_byte(8'h0A);
                            jsu_pkg::CH_R:     o_job = job_byte(8'h0D);
                            jsu_pkg::CH_T:     o_job = job_byte(8'h09);
                            jsu_pkg::CH_U: begin
                                o_push = 1'b0;
                                n_mode = jsu_pkg::MODE_HEX1;
                                n_cnt  = '0;
                                n_acc  = '0;
                            end
                            default: begin
                                o_job  = job_status(jsu_pkg::ST_BADESC);
                                n_cnt  = '0;
                                n_acc  = '0;
                                n_high = '0;
                            end
                        endcase
                    end
                    jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
                        if (w_hex[4]) begin
                            o_push = 1'b1;
                            o_job  = job_status(jsu_pkg::ST_BADHEX);
                            n_mode = jsu_pkg::MODE_NORMAL;
                            n_cnt  = '0;
                            n_acc  = '0;
                            n_high = '0;
                        end else if (r_cnt != 2'd3) begin
                            n_acc = w_acc;
                            n_cnt = r_cnt + 2'd1;
                        end else begin
                            n_cnt = '0;
                            n_acc = '0;
                            if (r_mode == jsu_pkg::MODE_HEX1) begin
                                if (w_acc >= 16'hD800 && w_acc <= 16'hDBFF) begin
                                    n_high = w_acc[9:0];
                                    n_mode = jsu_pkg::MODE_BSL;
                                end else if (w_acc >= 16'hDC00 && w_acc <= 16'hDFFF) begin
                                    o_push = 1'b1;
                                    o_job  = job_status(jsu_pkg::ST_BADLOW);
                                    n_mode = jsu_pkg::MODE_NORMAL;
                                    n_high = '0;
                                end else begin
                                    o_push = 1'b1;
                                    o_job  = job_utf8({5'd0, w_acc});
                                    n_mode = jsu_pkg::MODE_NORMAL;
                                end
                            end else begin
                                o_push = 1'b1;
                                n_mode = jsu_pkg::MODE_NORMAL;
                                n_high = '0;
                                if (w_acc >= 16'hDC00 && w_acc <= 16'hDFFF) begin
                                    o_job = job_utf8(w_pair);
                                end else begin
                                    o_job = job_status(jsu_pkg::ST_BADLOW);
                                end
                            end
                        end
                    end
                    jsu_pkg::MODE_BSL, jsu_pkg::MODE_U: begin
                        if ((r_mode == jsu_pkg::MODE_BSL && i_byte != jsu_pkg::CH_BSL) ||
                            (r_mode == jsu_pkg::MODE_U && i_byte != jsu_pkg::CH_U)) begin
                            o_push = 1'b1;
                            o_job  = job_status(jsu_pkg::ST_NOLOW);
                            n_mode = jsu_pkg::MODE_NORMAL;
                            n_cnt  = '0;
                            n_acc  = '0;
                            n_high = '0;
                        end else if (r_mode == jsu_pkg::MODE_BSL) begin
                            n_mode = jsu_pkg::MODE_U;
                        end else begin
                            n_mode = jsu_pkg::MODE_HEX2;
                            n_cnt  = '0;
                            n_acc  = '0;
                        end
                    end
                    default: begin
                        // Plain string body
                        n_mode = jsu_pkg::MODE_NORMAL;
                        if (i_byte == jsu_pkg::CH_QUOTE || i_byte < jsu_pkg::CH_SPACE) begin
                            o_push = 1'b1;
                            o_job  = job_status((i_byte == jsu_pkg::CH_QUOTE) ?
                                                jsu_pkg::ST_CLOSED : jsu_pkg::ST_CTRL);
                            n_cnt  = '0;
                            n_acc  = '0;
                            n_high = '0;
                        end else if (i_byte == jsu_pkg::CH_BSL) begin
                            n_mode = jsu_pkg::MODE_ESC;
                        end else begin
                            o_push = 1'b1;
                            o_job  = job_byte(i_byte);
                        end
                    end
                endcase
            end
        end
    end

    // Scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::MODE_NORMAL;
            r_cnt  <= '0;
            r_acc  <= '0;
            r_high <= '0;
        end else begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
            r_high <= n_high;
        end
    end

endmodule

// ===== hw/rtl/jsu_queue.sv =====
// Two-entry job queue between the scanner and the byte sender.
module jsu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output jsu_pkg::t_job o_job
);

    localparam int AW = $clog2(jsu_pkg::QDEPTH);

    jsu_pkg::t_job r_mem [jsu_pkg::QDEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(jsu_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule

// ===== hw/rtl/jsu_back.sv =====
// Back end: sends the bytes of each job one per transaction.
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  jsu_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_data,
    output logic [2:0]    o_status,
    output logic          o_last
);

    logic       r_valid;
    logic [7:0] r_data;
    logic [2:0] r_status;
    logic       r_last;
    logic [1:0] r_idx;
    logic       w_load, w_end;

    // Output register free or being drained this cycle
    assign w_load = i_job_valid && (!r_valid || i_ready);
    assign w_end  = (r_idx == i_job.last_idx);
    assign o_pop  = w_load && w_end;

    // Byte index within the current job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_end ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data   <= i_job.bytes[r_idx];
            r_status <= i_job.status;
            r_last   <= w_end;
        end
    end

    assign o_valid  = r_valid;
    assign o_data   = r_data;
    assign o_status = r_status;
    assign o_last   = r_last;

endmodule

// ===== hw/rtl/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
//
// channel  dir  tdata          tuser        tlast
// s        in   in_byte[7:0]   action[0]    -
// m        out  data_byte[7:0] status[2:0]  last
//
// One input byte per cycle is taken while the job queue has room.
// A \u escape that yields 2..4 UTF-8 bytes holds the byte sender until all are
// sent; bytes that follow can then fill the two-entry queue and stall the input.
// o_m_tvalid rises once a job is queued and then loaded into the output register.
// Reset is synchronous, active low, and clears the scanner, queue and sender.
// Output stalls only back up through the queue, never drop items.
module json_string_unescape_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic [0:0] i_s_tuser,   // [0] action
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] data_byte
    output logic [2:0] o_m_tuser,   // [2:0] status
    output logic       o_m_tlast
);

    logic          w_push, w_pop, w_full, w_qvalid, w_accept;
    jsu_pkg::t_job w_fjob, w_qjob;

    assign o_s_tready = !w_full;
    assign w_accept   = i_s_tvalid && !w_full;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_end    (i_s_tuser[0]),
        .i_byte   (i_s_tdata),
        .o_push   (w_push),
        .o_job    (w_fjob)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_job   (w_qjob)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_qvalid),
        .i_job       (w_qjob),
        .o_pop       (w_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata),
        .o_status    (o_m_tuser),
        .o_last      (o_m_tlast)
    );

endmodule
